>>> hw/rtl/sbsi_pkg.sv
// Shared widths and defaults for the swept box slab intersection core.
package sbsi_pkg;

  localparam int CW = 32;                 // Q16.16 coordinate
  localparam int HW = 31;                 // half-extent
  localparam int BW = 34;                 // grown bound
  localparam int NW = 35;                 // bound minus origin
  localparam int MW = 34;                 // numerator magnitude / remainder
  localparam int DW = 32;                 // divisor magnitude
  localparam int NLANE = 4;               // lo x, hi x, lo y, hi y
  localparam int FRACTION_BITS_DEF = 16;

  localparam int LN_LX = 0;
  localparam int LN_HX = 1;
  localparam int LN_LY = 2;
  localparam int LN_HY = 3;

  typedef struct packed {
    logic start_in;
    logic okx;
    logic oky;
    logic zx;
    logic zy;
    logic sweep;
    logic dxn;
    logic dyn;
  } sbsi_ctl_t;

endpackage

>>> hw/rtl/swept_box_slab_intersection_core.sv
// Pipelined segment / swept box against axis-aligned box slab test.
// One word in and one word out per cycle while the output is not stalled. Three
// stages build grown bounds, slab numerators and magnitudes, one stage checks
// quotient overflow, the four slab quotients then run through a restoring
// divider pipeline retiring two quotient bits per stage, and three stages
// clamp the quotients, merge the x slab and merge the y slab with the final
// checks. Every stage holds only while its successor is full and stalled,
// so bubbles collapse and a waiting result does not block new words.
module swept_box_slab_intersection_core #(
  parameter int FRACTION_BITS = sbsi_pkg::FRACTION_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               in_op,
  input  logic signed [sbsi_pkg::CW-1:0]     in_origin_x,
  input  logic signed [sbsi_pkg::CW-1:0]     in_origin_y,
  input  logic        [sbsi_pkg::HW-1:0]     in_half_x,
  input  logic        [sbsi_pkg::HW-1:0]     in_half_y,
  input  logic signed [sbsi_pkg::CW-1:0]     in_delta_x,
  input  logic signed [sbsi_pkg::CW-1:0]     in_delta_y,
  input  logic signed [sbsi_pkg::CW-1:0]     in_box_min_x,
  input  logic signed [sbsi_pkg::CW-1:0]     in_box_min_y,
  input  logic signed [sbsi_pkg::CW-1:0]     in_box_max_x,
  input  logic signed [sbsi_pkg::CW-1:0]     in_box_max_y,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               out_hit,
  output logic                               out_overlap_start,
  output logic        [FRACTION_BITS:0]      out_fraction,
  output logic signed [1:0]                  out_normal_x,
  output logic signed [1:0]                  out_normal_y
);
  import sbsi_pkg::*;

  localparam int TW   = FRACTION_BITS + 3;          // clamped slab time
  localparam int QW   = FRACTION_BITS + 1;          // quotient bits
  localparam int NSTEP = FRACTION_BITS + 1;
  localparam int SPS  = 2;                          // quotient bits per stage
  localparam int NDS  = (NSTEP + SPS - 1) / SPS;
  localparam int ST_DIV0 = 4;
  localparam int ST_Q  = ST_DIV0 + NDS;
  localparam int ST_X  = ST_Q + 1;
  localparam int ST_O  = ST_X + 1;
  localparam int NST   = ST_O + 1;

  localparam logic signed [TW-1:0] ONE_T  = TW'(1) <<< FRACTION_BITS;
  localparam logic signed [TW-1:0] ONEP_T = ONE_T + TW'(1);
  localparam logic        [QW:0]   ONEP_Q = (QW+1)'(1) << FRACTION_BITS | (QW+1)'(1);

  typedef struct packed {
    logic [MW-1:0] r;
    logic [QW-1:0] q;
    logic [DW-1:0] d;
    logic          ovf;
    logic          neg;
  } lane_t;

  // ---------------- handshake ----------------
  logic [NST-1:0] v_r;
  logic [NST-1:0] v_prev;
  logic [NST:0]   en;

  assign en[NST] = out_ready;
  for (genvar k = 0; k < NST; k++) begin : g_en
    assign en[k] = !v_r[k] || en[k+1];
  end
  assign in_ready  = en[0];
  assign out_valid = v_r[NST-1];
  assign v_prev    = {v_r[NST-2:0], in_valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int k = 0; k < NST; k++) begin
        if (en[k]) begin
          v_r[k] <= v_prev[k];
        end
      end
    end
  end

  // ---------------- stage 1: grown bounds ----------------
  logic                 s1_sw_r;
  logic signed [CW-1:0] s1_ox_r, s1_oy_r, s1_dx_r, s1_dy_r;
  logic signed [BW-1:0] s1_minx_r, s1_maxx_r, s1_miny_r, s1_maxy_r;
  logic signed [BW-1:0] hx, hy;

  assign hx = in_op ? signed'(BW'(in_half_x)) : '0;
  assign hy = in_op ? signed'(BW'(in_half_y)) : '0;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s1_sw_r   <= in_op;
      s1_ox_r   <= in_origin_x;
      s1_oy_r   <= in_origin_y;
      s1_dx_r   <= in_delta_x;
      s1_dy_r   <= in_delta_y;
      s1_minx_r <= BW'(in_box_min_x) - hx;
      s1_miny_r <= BW'(in_box_min_y) - hy;
      s1_maxx_r <= BW'(in_box_max_x) + hx;
      s1_maxy_r <= BW'(in_box_max_y) + hy;
    end
  end

  // ---------------- stage 2: numerators and containment ----------------
  sbsi_ctl_t            s2_c_r;
  logic signed [NW-1:0] s2_n_r [NLANE];
  logic signed [CW-1:0] s2_dx_r, s2_dy_r;
  logic signed [BW-1:0] ox_e, oy_e;

  assign ox_e = BW'(s1_ox_r);
  assign oy_e = BW'(s1_oy_r);

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s2_c_r.start_in <= (ox_e > s1_minx_r) && (ox_e < s1_maxx_r) &&
                         (oy_e > s1_miny_r) && (oy_e < s1_maxy_r);
      s2_c_r.okx    <= (ox_e >= s1_minx_r) && (ox_e <= s1_maxx_r);
      s2_c_r.oky    <= (oy_e >= s1_miny_r) && (oy_e <= s1_maxy_r);
      s2_c_r.zx     <= (s1_dx_r == '0);
      s2_c_r.zy     <= (s1_dy_r == '0);
      s2_c_r.sweep  <= s1_sw_r;
      s2_c_r.dxn    <= s1_dx_r[CW-1];
      s2_c_r.dyn    <= s1_dy_r[CW-1];
      s2_n_r[LN_LX] <= NW'(s1_minx_r) - NW'(ox_e);
      s2_n_r[LN_HX] <= NW'(s1_maxx_r) - NW'(ox_e);
      s2_n_r[LN_LY] <= NW'(s1_miny_r) - NW'(oy_e);
      s2_n_r[LN_HY] <= NW'(s1_maxy_r) - NW'(oy_e);
      s2_dx_r       <= s1_dx_r;
      s2_dy_r       <= s1_dy_r;
    end
  end

  // ---------------- stage 3: magnitudes ----------------
  sbsi_ctl_t     s3_c_r;
  logic [MW-1:0] s3_m_r [NLANE];
  logic          s3_neg_r [NLANE];
  logic [DW-1:0] s3_dmx_r, s3_dmy_r;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s3_c_r <= s2_c_r;
      for (int l = 0; l < NLANE; l++) begin
        s3_m_r[l]   <= s2_n_r[l][NW-1] ? MW'(-s2_n_r[l]) : MW'(s2_n_r[l]);
        s3_neg_r[l] <= s2_n_r[l][NW-1] ^ ((l < LN_LY) ? s2_c_r.dxn : s2_c_r.dyn);
      end
      s3_dmx_r <= s2_dx_r[CW-1] ? DW'(-s2_dx_r) : DW'(s2_dx_r);
      s3_dmy_r <= s2_dy_r[CW-1] ? DW'(-s2_dy_r) : DW'(s2_dy_r);
    end
  end

  // ---------------- stage 4: overflow check, divider load ----------------
  lane_t     dl_r [NDS+1][NLANE];
  sbsi_ctl_t dc_r [NDS+1];

  always_ff @(posedge clk) begin
    if (en[3]) begin
      dc_r[0] <= s3_c_r;
      for (int l = 0; l < NLANE; l++) begin
        dl_r[0][l].d   <= (l < LN_LY) ? s3_dmx_r : s3_dmy_r;
        // quotient at or above 2.0 saturates past the clamp anyway
        dl_r[0][l].ovf <= s3_m_r[l] >=
                          {1'b0, ((l < LN_LY) ? s3_dmx_r : s3_dmy_r), 1'b0};
        dl_r[0][l].r   <= s3_m_r[l];
        dl_r[0][l].q   <= '0;
        dl_r[0][l].neg <= s3_neg_r[l];
      end
    end
  end

  // ---------------- divider stages ----------------
  for (genvar j = 1; j <= NDS; j++) begin : g_div
    lane_t nx_l [NLANE];

    always_comb begin
      logic [MW-1:0] rr;
      logic [QW-1:0] qq;
      for (int l = 0; l < NLANE; l++) begin
        nx_l[l] = dl_r[j-1][l];
        rr = dl_r[j-1][l].r;
        qq = dl_r[j-1][l].q;
        for (int s = 0; s < SPS; s++) begin
          if ((j-1)*SPS + s < NSTEP) begin
            if ((j-1)*SPS + s != 0) begin
              rr = rr << 1;
            end
            if (rr >= MW'(dl_r[j-1][l].d)) begin
              rr = rr - MW'(dl_r[j-1][l].d);
              qq = {qq[QW-2:0], 1'b1};
            end else begin
              qq = {qq[QW-2:0], 1'b0};
            end
          end
        end
        nx_l[l].r = rr;
        nx_l[l].q = qq;
      end
    end

    always_ff @(posedge clk) begin
      if (en[ST_DIV0+j-1]) begin
        dc_r[j] <= dc_r[j-1];
        for (int l = 0; l < NLANE; l++) begin
          dl_r[j][l] <= nx_l[l];
        end
      end
    end
  end

  // ---------------- clamp and sign ----------------
  // Times are clamped to [-(1.0+lsb), 1.0+lsb]; ordering against 0 and 1.0
  // is kept, which is all the slab merge looks at.
  sbsi_ctl_t            sq_c_r;
  logic signed [TW-1:0] sq_t_r [NLANE];

  always_ff @(posedge clk) begin
    if (en[ST_Q]) begin
      sq_c_r <= dc_r[NDS];
      for (int l = 0; l < NLANE; l++) begin
        if (dl_r[NDS][l].ovf || ({1'b0, dl_r[NDS][l].q} > ONEP_Q)) begin
          sq_t_r[l] <= dl_r[NDS][l].neg ? -ONEP_T : ONEP_T;
        end else begin
          sq_t_r[l] <= dl_r[NDS][l].neg ? -signed'(TW'(dl_r[NDS][l].q))
                                        :  signed'(TW'(dl_r[NDS][l].q));
        end
      end
    end
  end

  // ---------------- x slab ----------------
  sbsi_ctl_t            sx_c_r;
  logic signed [TW-1:0] sx_tmin_r, sx_tmax_r, sx_ty1_r, sx_ty2_r;
  logic signed [1:0]    sx_nx_r;
  logic signed [TW-1:0] xa, xb, xmin, xmax;
  logic signed [1:0]    xn, xnx;
  logic                 xok;
  sbsi_ctl_t            xc;

  always_comb begin
    xa  = sq_t_r[LN_LX];
    xb  = sq_t_r[LN_HX];
    xn  = -2'sd1;
    if (xa > xb) begin
      xa = sq_t_r[LN_HX];
      xb = sq_t_r[LN_LX];
      xn = 2'sd1;
    end
    xmin = '0;
    xnx  = '0;
    if (xa > 0) begin
      xmin = xa;
      xnx  = xn;
    end
    xmax = (xb < ONE_T) ? xb : ONE_T;
    xok  = xmin <= xmax;
    if (sq_c_r.zx) begin
      xmin = '0;
      xmax = ONE_T;
      xnx  = '0;
      xok  = sq_c_r.okx;
    end
    xc     = sq_c_r;
    xc.okx = xok;
  end

  always_ff @(posedge clk) begin
    if (en[ST_X]) begin
      sx_c_r     <= xc;
      sx_tmin_r  <= xmin;
      sx_tmax_r  <= xmax;
      sx_nx_r    <= xnx;
      sx_ty1_r   <= sq_t_r[LN_LY];
      sx_ty2_r   <= sq_t_r[LN_HY];
    end
  end

  // ---------------- y slab and final checks ----------------
  logic signed [TW-1:0] ya, yb, ymin, ymax;
  logic signed [1:0]    yn, fnx, fny;
  logic                 yok, dot_neg, hit_c, so_c;

  always_comb begin
    ya   = sx_ty1_r;
    yb   = sx_ty2_r;
    yn   = -2'sd1;
    if (ya > yb) begin
      ya = sx_ty2_r;
      yb = sx_ty1_r;
      yn = 2'sd1;
    end
    ymin = sx_tmin_r;
    fnx  = sx_nx_r;
    fny  = '0;
    ymax = sx_tmax_r;
    if (!sx_c_r.zy) begin
      if (ya > sx_tmin_r) begin
        ymin = ya;
        fnx  = '0;
        fny  = yn;
      end
      if (yb < sx_tmax_r) begin
        ymax = yb;
      end
    end
    yok = sx_c_r.zy ? sx_c_r.oky : (ymin <= ymax);

    // normal against delta: strictly opposing only
    dot_neg = (fnx == 2'sd1  && sx_c_r.dxn) ||
              (fnx == -2'sd1 && !sx_c_r.dxn && !sx_c_r.zx) ||
              (fny == 2'sd1  && sx_c_r.dyn) ||
              (fny == -2'sd1 && !sx_c_r.dyn && !sx_c_r.zy);

    so_c  = sx_c_r.start_in;
    hit_c = sx_c_r.okx && yok && (ymin >= 0) && (ymin <= ONE_T) &&
            !(sx_c_r.sweep && (ymin <= 0) && !dot_neg);
    if (so_c) begin
      hit_c = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en[ST_O]) begin
      out_hit           <= hit_c;
      out_overlap_start <= so_c;
      if (hit_c && !so_c) begin
        out_fraction <= ymin[FRACTION_BITS:0];
        out_normal_x <= fnx;
        out_normal_y <= fny;
      end else begin
        out_fraction <= '0;
        out_normal_x <= '0;
        out_normal_y <= '0;
      end
    end
  end

  // ---------------- assertions ----------------
  a_so_implies_hit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_overlap_start |-> out_hit)
    else $error("overlap word without hit");

  a_miss_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_hit |->
      out_fraction == '0 && out_normal_x == 2'sd0 && out_normal_y == 2'sd0)
    else $error("miss word carries data");

  a_one_normal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_normal_x != 2'sd0 && out_normal_y != 2'sd0))
    else $error("two normal components set");

  a_frac_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_fraction <= ONE_T[FRACTION_BITS:0] || out_fraction[FRACTION_BITS] == 1'b0)
    else $error("fraction beyond 1.0");

endmodule
